// ===== hw/rtl/ils_pkg.sv =====
// Shared types and character codes for the integer literal scanner.
package ils_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_t;

  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic [63:0] accum;
    logic        digit_err;
    logic        ovf;
  } scan_state_t;

  typedef struct packed {
    logic [63:0] value;
    radix_t      radix;
    logic        bad_digit;
    logic        overflowed;
  } scan_result_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam scan_state_t SCAN_CLEAR = '{
    phase:     PH_IDLE,
    radix:     RADIX_DEC,
    accum:     64'd0,
    digit_err: 1'b0,
    ovf:       1'b0
  };

endpackage

// ===== hw/rtl/integer_literal_scanner_unit.sv =====
// A character that ends a literal waits in the input register until the result
// register is free or being emptied, and its result is then loaded into it.
// Throughput: one character per cycle while the result register is free or emptied;
// the 64-bit shift-add and carry check of the accumulator feeds the state register.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner to
// idle with a cleared accumulator and flags.
module integer_literal_scanner_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_value,
  output logic [1:0]          out_base_code,
  output logic                out_bad_digit,
  output logic                out_overflowed
);
  import ils_pkg::*;

  logic         ch_valid_r;
  logic [7:0]   ch_r;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  logic         emit;
  scan_result_t result;
  logic         out_valid_r;
  scan_result_t result_r;
  logic         advance;

  ils_step u_step (
    .state_i     (state_r),
    .ch_i        (ch_r),
    .state_nxt_o (state_nxt),
    .emit_o      (emit),
    .result_o    (result)
  );

  // The held character is processed once the result register is free or being emptied.
  assign advance  = ch_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ch_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= 1'b0;
    end else if (in_ready) begin
      ch_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = result_r.value;
  assign out_base_code  = result_r.radix;
  assign out_bad_digit  = result_r.bad_digit;
  assign out_overflowed = result_r.overflowed;

endmodule

// ===== hw/rtl/ils_step.sv =====
// Next-state and result logic of the scanner for one character.
module ils_step (
  input  ils_pkg::scan_state_t  state_i,
  input  logic [7:0]            ch_i,
  output ils_pkg::scan_state_t  state_nxt_o,
  output logic                  emit_o,
  output ils_pkg::scan_result_t result_o
);
  import ils_pkg::*;

  logic       is_dec;
  logic       is_lc;
  logic       is_uc;
  logic       is_hex;
  logic [3:0] digit;

  // Multiply by the base as a shift-add, then add the digit; any carry out of
  // 64 bits is an overflow.
  function automatic scan_state_t take_digit(scan_state_t s_in, logic [3:0] d);
    scan_state_t s;
    logic [4:0]  base;
    logic [3:0]  dv;
    logic [67:0] wide;
    logic [67:0] prod;
    begin
      s    = s_in;
      wide = {4'd0, s_in.accum};
      case (s_in.radix)
        RADIX_DEC: begin
          base = 5'd10;
          prod = (wide << 3) + (wide << 1);
        end
        RADIX_HEX: begin
          base = 5'd16;
          prod = wide << 4;
        end
        RADIX_BIN: begin
          base = 5'd2;
          prod = wide << 1;
        end
        RADIX_OCT: begin
          base = 5'd8;
          prod = wide << 3;
        end
        default: begin
          base = 5'd10;
          prod = (wide << 3) + (wide << 1);
        end
      endcase
      dv = d;
      if (!s_in.ovf) begin
        if ({1'b0, d} >= base) begin
          s.digit_err = 1'b1;
          dv = 4'd0;
        end
        prod = prod + {64'd0, dv};
        if (prod[67:64] != 4'd0) begin
          s.ovf   = 1'b1;
          s.accum = 64'd0;
        end else begin
          s.accum = prod[63:0];
        end
      end
      return s;
    end
  endfunction

  always_comb begin
    is_dec = (ch_i >= CH_0) && (ch_i <= CH_9);
    is_lc  = (ch_i >= CH_LC_A) && (ch_i <= CH_LC_F);
    is_uc  = (ch_i >= CH_UC_A) && (ch_i <= CH_UC_F);
    is_hex = is_dec || is_lc || is_uc;
    if (is_dec) begin
      digit = 4'(ch_i - CH_0);
    end else if (is_lc) begin
      digit = 4'(ch_i - CH_LC_A + 8'd10);
    end else if (is_uc) begin
      digit = 4'(ch_i - CH_UC_A + 8'd10);
    end else begin
      digit = 4'd0;
    end
  end

  always_comb begin
    state_nxt_o         = state_i;
    emit_o              = 1'b0;
    result_o.value      = state_i.ovf ? 64'd0 : state_i.accum;
    result_o.radix      = state_i.radix;
    result_o.bad_digit  = state_i.digit_err;
    result_o.overflowed = state_i.ovf;
    case (state_i.phase)
      PH_ZERO: begin
        if ((ch_i == CH_LC_X) || (ch_i == CH_UC_X)) begin
          state_nxt_o.radix = RADIX_HEX;
          state_nxt_o.phase = PH_DIGITS;
        end else if ((ch_i == CH_LC_B) || (ch_i == CH_UC_B)) begin
          state_nxt_o.radix = RADIX_BIN;
          state_nxt_o.phase = PH_DIGITS;
        end else if (is_dec) begin
          state_nxt_o.radix = RADIX_OCT;
          state_nxt_o.phase = PH_DIGITS;
          state_nxt_o       = take_digit(state_nxt_o, digit);
        end else if (is_hex) begin
          state_nxt_o.radix = RADIX_DEC;
          state_nxt_o.phase = PH_DIGITS;
          state_nxt_o       = take_digit(state_nxt_o, digit);
        end else begin
          emit_o         = 1'b1;
          result_o.radix = RADIX_DEC;
          state_nxt_o    = SCAN_CLEAR;
        end
      end
      PH_DIGITS: begin
        if (is_hex) begin
          state_nxt_o = take_digit(state_i, digit);
        end else begin
          emit_o      = 1'b1;
          state_nxt_o = SCAN_CLEAR;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves the same.
        if (ch_i == CH_0) begin
          state_nxt_o       = SCAN_CLEAR;
          state_nxt_o.phase = PH_ZERO;
        end else if ((ch_i >= CH_1) && (ch_i <= CH_9)) begin
          state_nxt_o       = SCAN_CLEAR;
          state_nxt_o.phase = PH_DIGITS;
          state_nxt_o.accum = {60'd0, digit};
        end else begin
          state_nxt_o.phase = PH_IDLE;
        end
      end
    endcase
  end

endmodule
